// File: rtl/window_pooling_2d_top_macros.svh
// -----------------------------------------------------------------------------
// window_pooling_2d_top_macros.svh
// Assertion macros used by the window pooling checker.
// -----------------------------------------------------------------------------
`ifndef WINDOW_POOLING_2D_TOP_MACROS_SVH
`define WINDOW_POOLING_2D_TOP_MACROS_SVH

// same-cycle implication
`define WP2D_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WP2D_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/wp2d_pkg.sv
// -----------------------------------------------------------------------------
// wp2d_pkg
// Shared types and constants of the 2-D window pooling block.
// -----------------------------------------------------------------------------
package wp2d_pkg;

   localparam int IMG_W      = 9;
   localparam int WIN_W      = 3;
   localparam int STRIDE_W   = 3;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int POS_W      = 8;
   localparam int STRIDE_MAX = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_SIZE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_MODE   = 2'd3;

   localparam logic [MODE_W-1:0] MODE_MAX = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MIN = 2'd1;
   localparam logic [MODE_W-1:0] MODE_AVG = 2'd2;

   localparam logic [WIN_W-1:0]    WINDOW_SIZE_RST = 3'd2;
   localparam logic [STRIDE_W-1:0] STRIDE_RST      = 3'd2;
   localparam logic [IMG_W-1:0]    IMAGE_SIZE_RST  = 9'd256;
   localparam logic [MODE_W-1:0]   POOL_MODE_RST   = MODE_MAX;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// File: rtl/window_pooling_2d_top.sv
// -----------------------------------------------------------------------------
// window_pooling_2d_top
// Streaming max / min / average pooling over square image planes.
//
//  channel   ports                          direction
//  req       req_valid/req_stall, pixel     in
//  rsp       rsp_valid/rsp_stall, result    out
//  csr       csr_we, csr_index, csr_wdata   in (write only)
//
// A pixel that completes no window leaves the block ready for the next one. A
// pixel that completes a window of side f holds req_stall while the f*f samples
// go through the single read port of the line store and, for the average, the
// one-bit-per-cycle divider (SUM_W = SAMPLE_BITS+2*clog2(MAX_WINDOW+1) bits, 22
// by default). Synchronous reset, no clearing pass. The next pixel is taken
// while a result waits on rsp_stall, until another result is due.
// -----------------------------------------------------------------------------
module window_pooling_2d_top
   import wp2d_pkg::*;
#(
   parameter int MAX_WINDOW  = 4,
   parameter int MAX_SIZE    = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_pixel,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_pooled_value,
   output logic [POS_W-1:0]              rsp_out_row,
   output logic [POS_W-1:0]              rsp_out_col,
   output logic                          rsp_last_of_map
);

   localparam int CNT_W  = $clog2(MAX_SIZE);
   localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int ST_W   = SLOT_W + 1;
   localparam int FW     = $clog2(MAX_WINDOW + 1);
   localparam int AREA_W = 2 * FW;
   localparam int SUM_W  = SAMPLE_BITS + AREA_W;
   localparam int CW     = ((CNT_W > IMG_W) ? CNT_W : IMG_W) + 2;
   localparam int ADDR_W = SLOT_W + CNT_W;

   // configuration
   logic [WIN_W-1:0]    window_size_ff;
   logic [STRIDE_W-1:0] stride_ff;
   logic [IMG_W-1:0]    image_size_ff;
   logic [MODE_W-1:0]   pool_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RST;
         stride_ff      <= STRIDE_RST;
         image_size_ff  <= IMAGE_SIZE_RST;
         pool_mode_ff   <= POOL_MODE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_SIZE: window_size_ff <= csr_wdata[WIN_W-1:0];
            CSR_STRIDE:      stride_ff      <= csr_wdata[STRIDE_W-1:0];
            CSR_IMAGE_SIZE:  image_size_ff  <= csr_wdata[IMG_W-1:0];
            CSR_POOL_MODE:   pool_mode_ff   <= csr_wdata[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   logic [FW-1:0] f_eff;
   logic [1:0]    s_m1;
   logic [CW-1:0] n_eff;

   always_comb begin
      if (window_size_ff == '0) begin
         f_eff = FW'(1);
      end else if (CW'(window_size_ff) > CW'(MAX_WINDOW)) begin
         f_eff = FW'(MAX_WINDOW);
      end else begin
         f_eff = FW'(window_size_ff);
      end

      if (stride_ff == '0) begin
         s_m1 = 2'd0;
      end else if (stride_ff > STRIDE_W'(STRIDE_MAX)) begin
         s_m1 = 2'(STRIDE_MAX - 1);
      end else begin
         s_m1 = 2'(stride_ff - STRIDE_W'(1));
      end

      if (image_size_ff == '0) begin
         n_eff = CW'(1);
      end else if (CW'(image_size_ff) > CW'(MAX_SIZE)) begin
         n_eff = CW'(MAX_SIZE);
      end else begin
         n_eff = CW'(image_size_ff);
      end
   end

   // handshake and state
   state_type state_ff, state_in;
   logic      accept;
   logic      rd_en;
   logic      div_start;
   logic      out_load;
   logic      out_free;
   logic      rsp_valid_ff, rsp_valid_in;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // raster scan position
   logic [CNT_W-1:0]  col_ff, col_in, row_ff, row_in;
   logic [1:0]        col_phase_ff, col_phase_in, row_phase_ff, row_phase_in;
   logic [POS_W-1:0]  ocol_ff, ocol_in, orow_ff, orow_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   logic [CW-1:0] c_ext, r_ext;
   logic          col_fit, row_fit, col_hit, row_hit, hit;
   logic          col_end, row_end, col_lastwin, row_lastwin;

   always_comb begin
      c_ext       = CW'(col_ff) + CW'(1);
      r_ext       = CW'(row_ff) + CW'(1);
      col_fit     = (c_ext >= CW'(f_eff));
      row_fit     = (r_ext >= CW'(f_eff));
      col_hit     = col_fit && (col_phase_ff == 2'd0);
      row_hit     = row_fit && (row_phase_ff == 2'd0);
      hit         = col_hit && row_hit;
      col_end     = (c_ext >= n_eff);
      row_end     = (r_ext >= n_eff);
      col_lastwin = ((c_ext + CW'(s_m1)) >= n_eff);
      row_lastwin = ((r_ext + CW'(s_m1)) >= n_eff);

      col_in       = col_ff;
      row_in       = row_ff;
      col_phase_in = col_phase_ff;
      row_phase_in = row_phase_ff;
      ocol_in      = ocol_ff;
      orow_in      = orow_ff;
      slot_in      = slot_ff;

      if (csr_we) begin
         col_in       = '0;
         row_in       = '0;
         col_phase_in = '0;
         row_phase_in = '0;
         ocol_in      = '0;
         orow_in      = '0;
         slot_in      = '0;
      end else if (accept) begin
         if (col_end) begin
            col_in       = '0;
            col_phase_in = '0;
            ocol_in      = '0;
            if (row_end) begin
               row_in       = '0;
               row_phase_in = '0;
               orow_in      = '0;
               slot_in      = '0;
            end else begin
               row_in       = row_ff + CNT_W'(1);
               row_phase_in = (!row_fit || row_phase_ff == s_m1) ? 2'd0 : row_phase_ff + 2'd1;
               orow_in      = row_hit ? orow_ff + POS_W'(1) : orow_ff;
               slot_in      = (slot_ff == SLOT_W'(MAX_WINDOW - 1)) ? '0 : slot_ff + SLOT_W'(1);
            end
         end else begin
            col_in       = col_ff + CNT_W'(1);
            col_phase_in = (!col_fit || col_phase_ff == s_m1) ? 2'd0 : col_phase_ff + 2'd1;
            ocol_in      = col_hit ? ocol_ff + POS_W'(1) : ocol_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         col_phase_ff <= '0;
         row_phase_ff <= '0;
         ocol_ff      <= '0;
         orow_ff      <= '0;
         slot_ff      <= '0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         col_phase_ff <= col_phase_in;
         row_phase_ff <= row_phase_in;
         ocol_ff      <= ocol_in;
         orow_ff      <= orow_in;
         slot_ff      <= slot_in;
      end
   end

   // window read sequencer
   logic [ST_W-1:0]   st_tmp;
   logic [SLOT_W-1:0] start_slot;
   logic [CNT_W-1:0]  win_c0_ff;
   logic [FW-1:0]     f_ff;
   logic [MODE_W-1:0] mode_ff;
   logic [POS_W-1:0]  res_row_ff, res_col_ff;
   logic              res_last_ff;
   logic [SLOT_W-1:0] rd_slot_ff, rd_slot_in;
   logic [FW-1:0]     rd_k_ff, rd_k_in, rd_p_ff, rd_p_in;
   logic              last_issue;
   logic              rd_vld_ff, rd_first_ff;
   logic [ADDR_W-1:0] rd_addr;

   always_comb begin
      st_tmp     = ST_W'(slot_ff) + ST_W'(MAX_WINDOW) - ST_W'(f_eff - FW'(1));
      start_slot = (st_tmp >= ST_W'(MAX_WINDOW)) ? SLOT_W'(st_tmp - ST_W'(MAX_WINDOW))
                                                 : SLOT_W'(st_tmp);
      last_issue = (rd_p_ff == f_ff - FW'(1)) && (rd_k_ff == f_ff - FW'(1));
      rd_addr    = {rd_slot_ff, win_c0_ff + CNT_W'(rd_p_ff)};

      rd_slot_in = rd_slot_ff;
      rd_k_in    = rd_k_ff;
      rd_p_in    = rd_p_ff;
      if (accept && hit) begin
         rd_slot_in = start_slot;
         rd_k_in    = '0;
         rd_p_in    = '0;
      end else if (rd_en) begin
         if (rd_p_ff == f_ff - FW'(1)) begin
            rd_p_in    = '0;
            rd_k_in    = rd_k_ff + FW'(1);
            rd_slot_in = (rd_slot_ff == SLOT_W'(MAX_WINDOW - 1)) ? '0
                                                                 : rd_slot_ff + SLOT_W'(1);
         end else begin
            rd_p_in = rd_p_ff + FW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && hit) begin
         win_c0_ff   <= CNT_W'(c_ext - CW'(f_eff));
         f_ff        <= f_eff;
         mode_ff     <= pool_mode_ff;
         res_row_ff  <= orow_ff;
         res_col_ff  <= ocol_ff;
         res_last_ff <= col_lastwin && row_lastwin;
      end
      rd_slot_ff <= rd_slot_in;
      rd_k_ff    <= rd_k_in;
      rd_p_ff    <= rd_p_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         rd_first_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= rd_en;
         rd_first_ff <= rd_en && (rd_k_ff == '0) && (rd_p_ff == '0);
      end
   end

   logic [SAMPLE_BITS-1:0] rd_data;

   wp2d_line_store #(
      .ADDR_W (ADDR_W),
      .DATA_W (SAMPLE_BITS)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr ({slot_ff, col_ff}),
      .wr_data (req_pixel),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // reduction
   logic signed [SAMPLE_BITS-1:0] rd_sample;
   logic signed [SAMPLE_BITS-1:0] best_ff;
   logic signed [SUM_W-1:0]       sum_ff;
   logic                          take;

   always_comb begin
      rd_sample = $signed(rd_data);
      take      = (mode_ff == MODE_MIN) ? (rd_sample < best_ff) : (rd_sample > best_ff);
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         if (rd_first_ff) begin
            best_ff <= rd_sample;
            sum_ff  <= SUM_W'(rd_sample);
         end else begin
            if (take) begin
               best_ff <= rd_sample;
            end
            sum_ff <= sum_ff + SUM_W'(rd_sample);
         end
      end
   end

   // mean
   logic signed [SUM_W-1:0] div_quot;
   div_stat_type            div_stat;

   wp2d_div #(
      .NUM_W (SUM_W),
      .DEN_W (AREA_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (sum_ff),
      .den   (AREA_W'(f_ff) * AREA_W'(f_ff)),
      .quot  (div_quot),
      .stat  (div_stat)
   );

   // state machine
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (accept && hit) state_in = ST_READ;
         ST_READ:     if (last_issue) state_in = ST_DRAIN;
         ST_DRAIN:    state_in = (mode_ff == MODE_AVG) ? ST_DIV_GO : ST_OUT;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (div_stat.done) state_in = ST_OUT;
         ST_OUT:      if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE:     req_stall = 1'b0;
         ST_READ:     rd_en = 1'b1;
         ST_DRAIN:    ;
         ST_DIV_GO:   div_start = 1'b1;
         ST_DIV_WAIT: ;
         ST_OUT:      out_load = out_free;
         default:     ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // output register
   logic signed [SAMPLE_BITS-1:0] rsp_value_ff;
   logic [POS_W-1:0]              rsp_row_ff, rsp_col_ff;
   logic                          rsp_last_ff;

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_value_ff <= (mode_ff == MODE_AVG) ? $signed(div_quot[SAMPLE_BITS-1:0]) : best_ff;
         rsp_row_ff   <= res_row_ff;
         rsp_col_ff   <= res_col_ff;
         rsp_last_ff  <= res_last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pooled_value = rsp_value_ff;
   assign rsp_out_row      = rsp_row_ff;
   assign rsp_out_col      = rsp_col_ff;
   assign rsp_last_of_map  = rsp_last_ff;

endmodule

// File: rtl/wp2d_line_store.sv
// -----------------------------------------------------------------------------
// wp2d_line_store
// Row buffer RAM: one write port, one read port, registered read data.
// -----------------------------------------------------------------------------
module wp2d_line_store #(
   parameter int ADDR_W = 10,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/wp2d_div.sv
// -----------------------------------------------------------------------------
// wp2d_div
// Radix-2 restoring divider, signed dividend by unsigned divisor,
// quotient truncated toward zero. One quotient bit per cycle.
// -----------------------------------------------------------------------------
module wp2d_div
   import wp2d_pkg::*;
#(
   parameter int NUM_W = 22,
   parameter int DEN_W = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] num,
   input  logic [DEN_W-1:0]        den,
   output logic signed [NUM_W-1:0] quot,
   output div_stat_type            stat
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W:0]          rem_ff, rem_in;
   logic [NUM_W-1:0]        quo_ff, quo_in;
   logic [DEN_W-1:0]        den_ff, den_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic                    neg_ff, neg_in;
   logic signed [NUM_W-1:0] res_ff, res_in;

   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_sub;
   logic             qbit;
   logic [NUM_W-1:0] quo_next;
   logic [NUM_W-1:0] num_mag;

   always_comb begin
      rem_sh   = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      qbit     = (rem_sh >= {1'b0, den_ff});
      rem_sub  = qbit ? (rem_sh - {1'b0, den_ff}) : rem_sh;
      quo_next = {quo_ff[NUM_W-2:0], qbit};
      num_mag  = num[NUM_W-1] ? unsigned'(-num) : unsigned'(num);

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in  = '0;
         quo_in  = num_mag;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
         neg_in  = num[NUM_W-1];
      end else if (busy_ff) begin
         rem_in = rem_sub;
         quo_in = quo_next;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? -$signed(quo_next) : $signed(quo_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign quot      = res_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// File: rtl/wp2d_checker.sv
// -----------------------------------------------------------------------------
// wp2d_checker
// Port-level checks of the window pooling block, bound to the top level.
// -----------------------------------------------------------------------------
`include "window_pooling_2d_top_macros.svh"

module wp2d_checker
   import wp2d_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [SAMPLE_BITS-1:0] rsp_pooled_value,
   input logic [POS_W-1:0]              rsp_out_row,
   input logic [POS_W-1:0]              rsp_out_col,
   input logic                          rsp_last_of_map
);

   `WP2D_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp dropped while stalled")
   `WP2D_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_pooled_value) && $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_last_of_map), "rsp payload changed while stalled")
   `WP2D_ASSERT_IMP(a_last_diag, clock, reset, rsp_valid && rsp_last_of_map, rsp_out_row == rsp_out_col, "last result off the map diagonal")
   `WP2D_ASSERT_IMP(a_rsp_after_work, clock, reset, $rose(rsp_valid), $past(req_stall) && (req_valid || !req_valid), "result without a window in progress")

endmodule

bind window_pooling_2d_top wp2d_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_wp2d_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_pooled_value (rsp_pooled_value),
   .rsp_out_row      (rsp_out_row),
   .rsp_out_col      (rsp_out_col),
   .rsp_last_of_map  (rsp_last_of_map)
);
